// ----- rtl/tbg_pkg.sv -----
package tbg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int MAX_CHANNELS   = 8;

  localparam int AMPLITUDE   = 16000;
  localparam int SINE_W      = 14;
  localparam int SAMPLE_W    = 15;
  localparam int CHAN_OUT_W  = 3;
  localparam int OUT_LIMIT   = 8;
  localparam int TABLE_DEPTH = (1 << SINE_ADDR_BITS) + 1;
  localparam int ROM_AW      = SINE_ADDR_BITS + 1;
  localparam int CHAN_W      = $clog2(MAX_CHANNELS + 1);
  localparam int EFF_MAX     = (MAX_CHANNELS < OUT_LIMIT) ? MAX_CHANNELS : OUT_LIMIT;

  localparam int BLOCK_W = 11;
  localparam int BEEP_W  = 24;
  localparam int STEP_W  = 32;
  localparam int CCNT_W  = 4;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 32;

  localparam logic [BLOCK_W-1:0] BLOCK_RESET = BLOCK_W'(480);
  localparam logic [BEEP_W-1:0]  BEEP_RESET  = BEEP_W'(9600);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(89478485);
  localparam logic [CCNT_W-1:0]  CCNT_RESET  = CCNT_W'(1);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef longint unsigned ulong_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_BLOCK_SAMPLES = 2'd0,
    REG_BEEP_SAMPLES  = 2'd1,
    REG_PHASE_STEP    = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } cfg_reg_e;

  // per-tick info handed from the state update to the output side
  typedef struct packed {
    logic              neg;
    logic              tone;
    logic [CHAN_W-1:0] chans;
  } tick_t;

  typedef logic [SINE_W-1:0] sine_rom_t [TABLE_DEPTH];

  // shift and subtract quotient, only used while building the table
  function automatic ulong_t udiv_const(input ulong_t num, input ulong_t den);
    ulong_t q;
    ulong_t r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // quarter wave: q30 taylor series up to x^17, each term truncated
  function automatic sine_rom_t build_sine_table();
    sine_rom_t t;
    ulong_t    x;
    ulong_t    x2;
    ulong_t    term;
    longint    sum;
    for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
      x    = (ulong_t'(k) * HALF_PI_Q30) >> SINE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = udiv_const((term * x2) >> 30, ulong_t'((2 * n) * (2 * n + 1)));
        if (n[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      t[k] = SINE_W'((ulong_t'(sum) * ulong_t'(AMPLITUDE)) >> 30);
    end
    t[TABLE_DEPTH-1] = SINE_W'(AMPLITUDE);
    return t;
  endfunction

  // bring the 32 fraction bits of the step to the phase width
  function automatic logic [PHASE_BITS-1:0] align_step(input logic [STEP_W-1:0] s);
    logic [PHASE_BITS+STEP_W-1:0] w;
    w = {s, {PHASE_BITS{1'b0}}};
    return w[PHASE_BITS+STEP_W-1:STEP_W];
  endfunction

endpackage

// ----- rtl/triggered_tone_burst_generator.sv -----
// path: an accepted item goes through the table read and the stage one tick register,
// then the output register; a busy output serializer holds it in stage one
// output: each item goes out as channel_count copies (clamped to 1 to 8), one channel copy
// per cycle while the output is ready; stage one can take the next item while copies go out
// reset: rst_ni async low clears tick state and output valid, config to defaults
module triggered_tone_burst_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] beep_request, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [14:0] sample, [15] zero
  output logic [3:0]  m_axis_tuser,   // [2:0] channel, [3] tone_active
  output logic        m_axis_tlast
);
  import tbg_pkg::*;

  logic                  issue;
  tick_t                 tick;
  logic [ROM_AW-1:0]     rom_addr;
  logic [SINE_W-1:0]     rom_data;
  logic [SAMPLE_W-1:0]   sample;
  logic [CHAN_OUT_W-1:0] channel;
  logic                  tone;

  assign cfg_ready_o = 1'b1;
  assign issue       = s_axis_tvalid & s_axis_tready;

  tbg_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .issue_i        (issue),
    .beep_request_i (s_axis_tdata[0]),
    .tick_o         (tick),
    .rom_addr_o     (rom_addr)
  );

  tbg_sine_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (issue),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  tbg_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .tick_i     (tick),
    .rom_data_i (rom_data),
    .ready_o    (s_axis_tready),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .sample_o   (sample),
    .channel_o  (channel),
    .last_o     (m_axis_tlast),
    .tone_o     (tone)
  );

  assign m_axis_tdata = {1'b0, sample};
  assign m_axis_tuser = {tone, channel};

endmodule

// ----- rtl/tbg_sine_rom.sv -----
module tbg_sine_rom (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tbg_pkg::ROM_AW-1:0] addr_i,
  output logic [tbg_pkg::SINE_W-1:0] data_o
);
  import tbg_pkg::*;

  localparam sine_rom_t SineRom = build_sine_table();

  logic [SINE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= SineRom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ----- rtl/tbg_state.sv -----
module tbg_state (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tbg_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [tbg_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       issue_i,
  input  logic                       beep_request_i,
  output tbg_pkg::tick_t             tick_o,
  output logic [tbg_pkg::ROM_AW-1:0] rom_addr_o
);
  import tbg_pkg::*;

  logic [BLOCK_W-1:0]    block_samples_q;
  logic [BEEP_W-1:0]     beep_samples_q;
  logic [STEP_W-1:0]     phase_step_q;
  logic [CCNT_W-1:0]     channel_count_q;

  logic                  pend_q, pend_d;
  logic [BLOCK_W-1:0]    pos_q, pos_d;
  logic [BEEP_W-1:0]     left_q, left_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic                  tone_q, tone_d;

  logic                      pend_now;
  logic                      start;
  logic                      load;
  logic [BEEP_W-1:0]         left_cur;
  logic [PHASE_BITS-1:0]     phase_cur;
  logic [BLOCK_W-1:0]        blen;
  logic [BLOCK_W:0]          pos_inc;
  logic [SINE_ADDR_BITS+1:0] idx;
  logic [SINE_ADDR_BITS-1:0] kk;
  logic [CHAN_W-1:0]         chans;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_samples_q <= BLOCK_RESET;
      beep_samples_q  <= BEEP_RESET;
      phase_step_q    <= STEP_RESET;
      channel_count_q <= CCNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_BLOCK_SAMPLES: block_samples_q <= cfg_data_i[BLOCK_W-1:0];
        REG_BEEP_SAMPLES:  beep_samples_q  <= cfg_data_i[BEEP_W-1:0];
        REG_PHASE_STEP:    phase_step_q    <= cfg_data_i[STEP_W-1:0];
        REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    blen      = (block_samples_q == '0) ? BLOCK_W'(1) : block_samples_q;
    pend_now  = pend_q | beep_request_i;
    start     = (pos_q == '0);
    load      = start & pend_now;
    left_cur  = load ? beep_samples_q : left_q;
    phase_cur = load ? '0 : phase_q;
    tone_d    = start ? (left_cur != '0) : tone_q;
    left_d    = left_cur;
    if (start && tone_d) begin
      left_d = (left_cur > BEEP_W'(blen)) ? left_cur - BEEP_W'(blen) : '0;
    end
    pend_d  = start ? 1'b0 : pend_now;
    phase_d = tone_d ? phase_cur + align_step(phase_step_q) : phase_cur;
    pos_inc = {1'b0, pos_q} + 1'b1;
    pos_d   = (pos_inc >= {1'b0, blen}) ? '0 : pos_inc[BLOCK_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      pos_q   <= '0;
      left_q  <= '0;
      phase_q <= '0;
      tone_q  <= 1'b0;
    end else if (issue_i) begin
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      phase_q <= phase_d;
      tone_q  <= tone_d;
    end
  end

  // top phase bits pick quadrant and table entry, odd quadrants mirrored
  always_comb begin
    idx = phase_cur[PHASE_BITS-1 -: SINE_ADDR_BITS+2];
    kk  = idx[SINE_ADDR_BITS-1:0];
    if (idx[SINE_ADDR_BITS]) begin
      rom_addr_o = ROM_AW'(1 << SINE_ADDR_BITS) - {1'b0, kk};
    end else begin
      rom_addr_o = {1'b0, kk};
    end
  end

  always_comb begin
    if (channel_count_q == '0) begin
      chans = CHAN_W'(1);
    end else if (32'(channel_count_q) > EFF_MAX) begin
      chans = CHAN_W'(EFF_MAX);
    end else begin
      chans = CHAN_W'(channel_count_q);
    end
    tick_o.neg   = idx[SINE_ADDR_BITS+1];
    tick_o.tone  = tone_d;
    tick_o.chans = chans;
  end

  a_phase_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !issue_i |=> $stable(phase_q))
    else $error("phase moved without an item");

  a_pend_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i && (pos_q == '0) |=> !pend_q)
    else $error("request still latched after block start");

  a_silence_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i && !tone_d && !load |=> $stable(phase_q))
    else $error("phase advanced in silence");

endmodule

// ----- rtl/tbg_out.sv -----
module tbg_out (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         issue_i,
  input  tbg_pkg::tick_t               tick_i,
  input  logic [tbg_pkg::SINE_W-1:0]   rom_data_i,
  output logic                         ready_o,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [tbg_pkg::SAMPLE_W-1:0] sample_o,
  output logic [tbg_pkg::CHAN_OUT_W-1:0] channel_o,
  output logic                         last_o,
  output logic                         tone_o
);
  import tbg_pkg::*;

  tick_t               s1_q;
  logic                s1_valid_q;
  logic                busy_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                tone_q;
  logic [CHAN_W-1:0]   chans_q;
  logic [CHAN_W-1:0]   chan_q;

  logic                out_fire;
  logic                out_done;
  logic                s1_move;
  logic [SAMPLE_W-1:0] mag;

  assign last_o   = (chan_q == chans_q - 1'b1);
  assign out_fire = busy_q & ready_i;
  assign out_done = out_fire & last_o;
  assign s1_move  = s1_valid_q & (~busy_q | out_done);
  assign ready_o  = ~s1_valid_q | s1_move;
  assign mag      = SAMPLE_W'(rom_data_i);

  // stage one: tick info waits beside the registered table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue_i | (s1_valid_q & ~s1_move);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_q <= tick_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      chan_q  <= '0;
      chans_q <= CHAN_W'(1);
    end else if (s1_move) begin
      busy_q  <= 1'b1;
      chan_q  <= '0;
      chans_q <= s1_q.chans;
    end else if (out_done) begin
      busy_q <= 1'b0;
    end else if (out_fire) begin
      chan_q <= chan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      tone_q   <= s1_q.tone;
      sample_q <= !s1_q.tone ? '0 : (s1_q.neg ? -mag : mag);
    end
  end

  assign valid_o   = busy_q;
  assign sample_o  = sample_q;
  assign tone_o    = tone_q;
  assign channel_o = CHAN_OUT_W'(chan_q);

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (chan_q < chans_q))
    else $error("channel counter beyond channel count");

  a_chan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_o |=> busy_q && (chan_q == $past(chan_q) + 1'b1))
    else $error("channel copy skipped or repeated");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q)
    else $error("pending tick lost");

  a_start_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> busy_q && (chan_q == '0))
    else $error("tick did not start at channel zero");

endmodule

// ----- tb/tone_burst_checker.sv -----
`timescale 1ns / 1ps

module tone_burst_checker
  import tbg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        tick_valid_i,
  input  logic        tick_ready_i,
  input  logic [7:0]  tick_data_i,
  input  logic        copy_valid_i,
  input  logic        copy_ready_i,
  input  logic [15:0] copy_data_i,
  input  logic [3:0]  copy_user_i,
  input  logic        copy_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          tone_copies_o
);

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_OUT_W-1:0]      channel;
    logic                       last_copy;
    logic                       tone;
  } tone_copy_t;

  int quarter_wave [TABLE_DEPTH];

  // register shadows
  logic [BLOCK_W-1:0] blk_len;
  logic [BEEP_W-1:0]  beep_len;
  logic [STEP_W-1:0]  step;
  logic [CCNT_W-1:0]  chan_cnt;

  // tick state
  logic                  req_latched;
  logic [BLOCK_W-1:0]    blk_pos;
  logic [BEEP_W-1:0]     remain;
  logic [PHASE_BITS-1:0] phase;
  logic                  tone_blk;

  tone_copy_t expected_copies [$];
  tone_copy_t head;
  int fails;
  int checked;
  int tone_copies;

  // quarter sine in q30, truncated taylor terms up to x^17
  initial begin
    u64_t ang;
    u64_t ang_sq;
    u64_t term;
    longint acc;
    for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
      ang    = (u64_t'(k) * HALF_PI_Q30) >> SINE_ADDR_BITS;
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = longint'(ang);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * ang_sq) >> 30) / u64_t'(4 * n * n + 2 * n);
        acc  = n[0] ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      quarter_wave[k] = int'((u64_t'(acc) * u64_t'(AMPLITUDE)) >> 30);
    end
    quarter_wave[TABLE_DEPTH-1] = AMPLITUDE;
  end

  function automatic void predict_tick(input logic req);
    logic [BLOCK_W:0]             span;
    int                           copies;
    logic signed [SAMPLE_W-1:0]   pcm;
    logic [SINE_ADDR_BITS+1:0]    idx;
    int                           addr;
    int                           mag;
    tone_copy_t                   c;
    span   = (blk_len == '0) ? (BLOCK_W+1)'(1) : {1'b0, blk_len};
    copies = (chan_cnt == '0) ? 1 : int'(chan_cnt);
    if (copies > EFF_MAX) copies = EFF_MAX;
    pcm = '0;
    if (req) req_latched = 1'b1;
    if (blk_pos == '0) begin
      if (req_latched) begin
        remain      = beep_len;
        phase       = '0;
        req_latched = 1'b0;
      end
      tone_blk = (remain != '0);
      if (tone_blk) remain = (remain > BEEP_W'(span)) ? remain - BEEP_W'(span) : '0;
    end
    if (tone_blk) begin
      // top bits of the phase pick quadrant and table entry
      idx  = phase[PHASE_BITS-1 -: SINE_ADDR_BITS+2];
      addr = int'(idx[SINE_ADDR_BITS-1:0]);
      if (idx[SINE_ADDR_BITS]) addr = (1 << SINE_ADDR_BITS) - addr;
      mag   = quarter_wave[addr];
      pcm   = SAMPLE_W'(idx[SINE_ADDR_BITS+1] ? -mag : mag);
      phase = phase + align_step(step);
    end
    if ({1'b0, blk_pos} + 1 >= span) blk_pos = '0;
    else blk_pos = blk_pos + 1'b1;
    for (int i = 0; i < copies; i++) begin
      c.sample    = pcm;
      c.channel   = CHAN_OUT_W'(i);
      c.last_copy = (i == copies - 1);
      c.tone      = tone_blk;
      expected_copies.push_back(c);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_len     = BLOCK_RESET;
      beep_len    = BEEP_RESET;
      step        = STEP_RESET;
      chan_cnt    = CCNT_RESET;
      req_latched = 1'b0;
      blk_pos     = '0;
      remain      = '0;
      phase       = '0;
      tone_blk    = 1'b0;
      expected_copies.delete();
      fails       = 0;
      checked     = 0;
      tone_copies = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      tone_copies_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_BLOCK_SAMPLES: blk_len  = cfg_data_i[BLOCK_W-1:0];
          REG_BEEP_SAMPLES:  beep_len = cfg_data_i[BEEP_W-1:0];
          REG_PHASE_STEP:    step     = cfg_data_i[STEP_W-1:0];
          REG_CHANNEL_COUNT: chan_cnt = cfg_data_i[CCNT_W-1:0];
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) predict_tick(tick_data_i[0]);
      if (copy_valid_i && copy_ready_i) begin
        if (expected_copies.size() == 0) begin
          $error("unexpected channel copy: sample %0d channel %0d",
                 $signed(copy_data_i[SAMPLE_W-1:0]), copy_user_i[2:0]);
          fails++;
        end else begin
          head = expected_copies.pop_front();
          if (copy_data_i[SAMPLE_W-1:0] !== head.sample) begin
            $error("sample: expected %0d, got %0d", head.sample,
                   $signed(copy_data_i[SAMPLE_W-1:0]));
            fails++;
          end
          if (copy_user_i[2:0] !== head.channel) begin
            $error("channel: expected %0d, got %0d", head.channel, copy_user_i[2:0]);
            fails++;
          end
          if (copy_last_i !== head.last_copy) begin
            $error("last_channel: expected %0d, got %0d", head.last_copy, copy_last_i);
            fails++;
          end
          if (copy_user_i[3] !== head.tone) begin
            $error("tone_active: expected %0d, got %0d", head.tone, copy_user_i[3]);
            fails++;
          end
          checked++;
          if (head.tone) tone_copies++;
        end
      end
      fail_count_o  <= fails;
      pending_o     <= expected_copies.size();
      checked_o     <= checked;
      tone_copies_o <= tone_copies;
    end
  end

endmodule

// ----- tb/tb_triggered_tone_burst_generator.sv -----
`timescale 1ns / 1ps

module tb_triggered_tone_burst_generator;
  import tbg_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i    = '0;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [0] beep_request, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [14:0] sample, [15] zero
  logic [3:0]  m_axis_tuser;         // [2:0] channel, [3] tone_active
  logic        m_axis_tlast;

  int fail_count;
  int pending;
  int checked;
  int tone_copies;

  int gap_pct   = 0;
  int stall_pct = 0;
  int ticks_sent = 0;
  int settings_used = 1;

  int gap_tbl   [5] = '{0, 73, 0, 28, 0};
  int stall_tbl [5] = '{0, 0, 73, 28, 28};

  triggered_tone_burst_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  tone_burst_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (s_axis_tvalid),
    .tick_ready_i (s_axis_tready),
    .tick_data_i  (s_axis_tdata),
    .copy_valid_i (m_axis_tvalid),
    .copy_ready_i (m_axis_tready),
    .copy_data_i  (m_axis_tdata),
    .copy_user_i  (m_axis_tuser),
    .copy_last_i  (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .tone_copies_o(tone_copies)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // valid is left high after the handshake so back to back items need no toggle
  task automatic send_tick(input logic req);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, req};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
  endtask

  // hold the sender until every expected copy has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic cfg_write(input cfg_reg_e r, input logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= r;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_settings(input logic [31:0] blk, input logic [31:0] beep,
                                input logic [31:0] stp, input logic [31:0] chans);
    cfg_write(REG_BLOCK_SAMPLES, blk);
    cfg_write(REG_BEEP_SAMPLES, beep);
    cfg_write(REG_PHASE_STEP, stp);
    cfg_write(REG_CHANNEL_COUNT, chans);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: request on a block start, then a second one mid block
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drained();

    // block shortened below the current position, zero channels, max step;
    // two requests in a row merge into one burst
    apply_settings(2, 3, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < 8; i++) send_tick(i == 2 || i == 3);
    wait_drained();

    // zero block length, channel count above the maximum, empty beep
    apply_settings(0, 0, 32'h0000_0000, 15);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_drained();

    // quarter turn steps hit the peaks and the zero crossings
    apply_settings(0, 24'hFF_FFFF, 32'h4000_0000, 15);
    send_tick(1'b1);
    for (int i = 0; i < 4; i++) send_tick(1'b0);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      gap_pct   = gap_tbl[p];
      stall_pct = stall_tbl[p];
      if (p == 4) apply_settings(1920, 24'hFF_FFFF, $urandom, 8);
      else apply_settings($urandom_range(1, 6), $urandom_range(0, 24), $urandom,
                          $urandom_range(0, 15));
      for (int i = 0; i < 42; i++) send_tick($urandom_range(7) == 0);
      wait_drained();
    end

    gap_pct   = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    $display("sent %0d sample ticks under %0d register settings", ticks_sent, settings_used);
    $display("checked %0d channel copies, %0d of them inside tone blocks",
             checked, tone_copies);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tbg_pkg.sv
rtl/tbg_sine_rom.sv
rtl/tbg_state.sv
rtl/tbg_out.sv
rtl/triggered_tone_burst_generator.sv
tb/tone_burst_checker.sv
tb/tb_triggered_tone_burst_generator.sv
